// ----- design/eslt_pkg.sv -----
package eslt_pkg;

    localparam int CHANNELS    = 4;
    localparam int CH_W        = 2;
    localparam int CH_DEPTH    = 2 ** CH_W;
    localparam int BIN_W       = 24;
    localparam int CLAMP_W     = 16;
    localparam int SUM_W       = BIN_W + 2;
    localparam int AVG_W       = 40;
    localparam int LEVEL_W     = 16;
    localparam int LED_W       = 8;
    localparam int S_TDATA_W   = 96;
    localparam int M_TDATA_W   = 88;

    localparam int RECIP3_W    = 27;
    localparam int RECIP3_SH   = 28;
    localparam int PROD3_W     = SUM_W + RECIP3_W;
    localparam int QUOT3_W     = PROD3_W - RECIP3_SH;
    localparam int FRAC_SH     = 15;
    localparam int HIGH_W      = 40;
    localparam int DEN_W       = 41;
    localparam int H_W         = 17;
    localparam int WCNT_W      = $clog2(H_W);
    localparam int HS_W        = H_W + SUM_W;
    localparam int CD_DIGIT_W  = 4;
    localparam int CD_DIGITS   = 12;
    localparam int CD_W        = CD_DIGIT_W * CD_DIGITS;
    localparam int CD_CNT_W    = $clog2(CD_DIGITS);
    localparam int CD_DIV_W    = 7;
    localparam int LVL_PROD_W  = 33;
    localparam int LVL_SRC_W   = LVL_PROD_W - 7;

    localparam logic [RECIP3_W-1:0] RECIP3          = 27'd89478486;
    localparam logic [FRAC_SH-1:0]  FRAC_ONE_THIRD  = 15'd10922;
    localparam logic [FRAC_SH-1:0]  FRAC_TWO_THIRDS = 15'd21845;
    localparam logic [DEN_W-1:0]    EPS_Q16         = 41'd66;
    localparam logic [CD_DIV_W-1:0] DIV_ENERGY      = 7'd100;
    localparam logic [CD_DIV_W-1:0] DIV_AVG         = 7'd5;
    localparam logic [6:0]          LEVEL_SCALE     = 7'd100;
    localparam logic [AVG_W-1:0]    LEVEL_CAP_Q16   = 40'd42598400;
    localparam logic [LEVEL_W-1:0]  LEVEL_FORCED    = 16'd65000;
    localparam logic [LED_W-1:0]    LED_CAP         = 8'd255;
    localparam logic [CLAMP_W-1:0]  BIN_CAP         = 16'hFFFF;

    typedef struct packed {
        logic load;
        logic mul3;
        logic high;
        logic den_init;
        logic wdiv_step;
        logic mul_hs;
        logic cd_load_c;
        logic cd_step;
        logic cd_load_avg;
        logic finish;
        logic level;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic wdiv_last;
        logic cdiv_last;
    } sts_t;

endpackage

// ----- design/eslt_ctrl.sv -----
module eslt_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    output logic            s_tready,
    output logic            m_tvalid,
    input  logic            m_tready,
    input  eslt_pkg::sts_t  sts,
    output eslt_pkg::cmd_t  cmd
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DIV3   = 4'd1;
    localparam logic [3:0] S_HIGH   = 4'd2;
    localparam logic [3:0] S_DEN    = 4'd3;
    localparam logic [3:0] S_WDIV   = 4'd4;
    localparam logic [3:0] S_MULHS  = 4'd5;
    localparam logic [3:0] S_TIMES3 = 4'd6;
    localparam logic [3:0] S_CDIV1  = 4'd7;
    localparam logic [3:0] S_AVGLD  = 4'd8;
    localparam logic [3:0] S_CDIV2  = 4'd9;
    localparam logic [3:0] S_FINISH = 4'd10;
    localparam logic [3:0] S_LEVEL  = 4'd11;
    localparam logic [3:0] S_OUT    = 4'd12;

    logic [3:0] state_reg, state_next;
    logic       m_tvalid_reg, m_tvalid_next;
    logic       out_free;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        cmd = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.load = 1'b1;
                    state_next = S_DIV3;
                end
            end
            S_DIV3: begin
                cmd.mul3 = 1'b1;
                state_next = S_HIGH;
            end
            S_HIGH: begin
                cmd.high = 1'b1;
                state_next = S_DEN;
            end
            S_DEN: begin
                cmd.den_init = 1'b1;
                state_next = S_WDIV;
            end
            S_WDIV: begin
                cmd.wdiv_step = 1'b1;
                if (sts.wdiv_last) begin
                    state_next = S_MULHS;
                end
            end
            S_MULHS: begin
                cmd.mul_hs = 1'b1;
                state_next = S_TIMES3;
            end
            S_TIMES3: begin
                cmd.cd_load_c = 1'b1;
                state_next = S_CDIV1;
            end
            S_CDIV1: begin
                cmd.cd_step = 1'b1;
                if (sts.cdiv_last) begin
                    state_next = S_AVGLD;
                end
            end
            S_AVGLD: begin
                cmd.cd_load_avg = 1'b1;
                state_next = S_CDIV2;
            end
            S_CDIV2: begin
                cmd.cd_step = 1'b1;
                if (sts.cdiv_last) begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH: begin
                cmd.finish = 1'b1;
                state_next = S_LEVEL;
            end
            S_LEVEL: begin
                cmd.level = 1'b1;
                state_next = S_OUT;
            end
            S_OUT: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        priority if (cmd.out_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    a_cmd_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(cmd))
        else $error("more than one datapath command at once");

    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == S_DIV3))
        else $error("accepted request did not start processing");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_tvalid_reg || m_tready))
        else $error("result register overwritten before it was taken");

endmodule

// ----- design/eslt_dp.sv -----
module eslt_dp (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  eslt_pkg::cmd_t                       cmd,
    output eslt_pkg::sts_t                       sts,
    input  logic [eslt_pkg::CH_W-1:0]            in_channel,
    input  logic [eslt_pkg::BIN_W-1:0]           in_bin_zero,
    input  logic [eslt_pkg::BIN_W-1:0]           in_bin_one,
    input  logic [eslt_pkg::BIN_W-1:0]           in_bin_two,
    input  logic [eslt_pkg::BIN_W-1:0]           in_bin_three,
    output logic [eslt_pkg::CH_W-1:0]            out_channel,
    output logic [eslt_pkg::CLAMP_W-1:0]         clamped_zero,
    output logic [eslt_pkg::CLAMP_W-1:0]         clamped_one,
    output logic [eslt_pkg::CLAMP_W-1:0]         clamped_two,
    output logic [eslt_pkg::CLAMP_W-1:0]         clamped_three,
    output logic [eslt_pkg::LEVEL_W-1:0]         activity_level,
    output logic [eslt_pkg::LED_W-1:0]           led_brightness
);

    logic [eslt_pkg::CH_W-1:0]       ch_reg;
    logic [eslt_pkg::BIN_W-1:0]      b0_reg;
    logic [eslt_pkg::SUM_W-1:0]      sum_reg;
    logic [eslt_pkg::CLAMP_W-1:0]    cl_reg [4];
    logic [eslt_pkg::PROD3_W-1:0]    prod3_reg;
    logic [eslt_pkg::HIGH_W-1:0]     high_reg;
    logic [eslt_pkg::DEN_W-1:0]      den_reg;
    logic [eslt_pkg::DEN_W-1:0]      wrem_reg;
    logic [eslt_pkg::H_W-1:0]        hq_reg;
    logic [eslt_pkg::WCNT_W-1:0]     wcnt_reg;
    logic [eslt_pkg::HS_W-1:0]       hs_reg;
    logic [eslt_pkg::CD_W-1:0]       cd_num_reg;
    logic [eslt_pkg::CD_W-1:0]       cd_quo_reg;
    logic [eslt_pkg::CD_DIV_W-1:0]   cd_rem_reg;
    logic [eslt_pkg::CD_DIV_W-1:0]   cd_div_reg;
    logic [eslt_pkg::CD_CNT_W-1:0]   cd_cnt_reg;
    logic [eslt_pkg::AVG_W-1:0]      avg_reg;
    logic [eslt_pkg::LVL_PROD_W-1:0] lvl_prod_reg;
    logic [eslt_pkg::AVG_W-1:0]      state_reg [eslt_pkg::CH_DEPTH];

    logic [eslt_pkg::CH_W-1:0]       out_ch_reg;
    logic [eslt_pkg::CLAMP_W-1:0]    out_cl_reg [4];
    logic [eslt_pkg::LEVEL_W-1:0]    out_level_reg;
    logic [eslt_pkg::LED_W-1:0]      out_led_reg;

    logic                            ch_ok;
    logic [eslt_pkg::QUOT3_W-1:0]    quot3;
    logic [1:0]                      rem3;
    logic [eslt_pkg::FRAC_SH-1:0]    frac3;
    logic [eslt_pkg::HIGH_W-1:0]     high_val;
    logic [eslt_pkg::DEN_W-1:0]      den_val;
    logic [eslt_pkg::DEN_W:0]        wtrial;
    logic                            wge;
    logic [eslt_pkg::DEN_W-1:0]      wrem_step;
    logic [eslt_pkg::CD_DIGIT_W-1:0] cd_qbits;
    logic [eslt_pkg::CD_DIV_W-1:0]   cd_rem_step;
    logic [eslt_pkg::HS_W+1:0]       energy_num;
    logic [eslt_pkg::AVG_W+2:0]      avg_num;
    logic [eslt_pkg::LEVEL_W-1:0]    level_val;
    logic [eslt_pkg::LED_W-1:0]      led_val;

    function automatic logic [eslt_pkg::CLAMP_W-1:0] clamp_bin(
        input logic [eslt_pkg::BIN_W-1:0] b
    );
        return (|b[eslt_pkg::BIN_W-1:eslt_pkg::CLAMP_W]) ? eslt_pkg::BIN_CAP
                                                         : b[eslt_pkg::CLAMP_W-1:0];
    endfunction

    assign ch_ok = int'(ch_reg) < eslt_pkg::CHANNELS;

    assign quot3 = prod3_reg[eslt_pkg::PROD3_W-1:eslt_pkg::RECIP3_SH];
    assign rem3  = 2'(sum_reg - eslt_pkg::SUM_W'(quot3 + {quot3, 1'b0}));

    always_comb begin
        unique case (rem3)
            2'd1:    frac3 = eslt_pkg::FRAC_ONE_THIRD;
            2'd2:    frac3 = eslt_pkg::FRAC_TWO_THIRDS;
            default: frac3 = '0;
        endcase
    end

    assign high_val = {quot3, frac3};
    assign den_val  = {2'b0, b0_reg, {eslt_pkg::FRAC_SH{1'b0}}}
                    + {1'b0, high_reg} + eslt_pkg::EPS_Q16;

    assign wtrial    = {wrem_reg, 1'b0};
    assign wge       = wtrial >= {1'b0, den_reg};
    assign wrem_step = wge ? eslt_pkg::DEN_W'(wtrial - {1'b0, den_reg})
                           : eslt_pkg::DEN_W'(wtrial);

    always_comb begin
        logic [eslt_pkg::CD_DIV_W:0] r;
        r = {1'b0, cd_rem_reg};
        cd_qbits = '0;
        for (int k = 0; k < eslt_pkg::CD_DIGIT_W; k++) begin
            r = {r[eslt_pkg::CD_DIV_W-1:0], cd_num_reg[eslt_pkg::CD_W-1-k]};
            if (r >= {1'b0, cd_div_reg}) begin
                r = r - {1'b0, cd_div_reg};
                cd_qbits[eslt_pkg::CD_DIGIT_W-1-k] = 1'b1;
            end
        end
        cd_rem_step = r[eslt_pkg::CD_DIV_W-1:0];
    end

    assign energy_num = {1'b0, hs_reg, 1'b0} + {2'b0, hs_reg};
    assign avg_num    = {1'b0, state_reg[ch_reg], 2'b0}
                      + (eslt_pkg::AVG_W+3)'(cd_quo_reg[eslt_pkg::AVG_W-1:0]);

    always_comb begin
        if (!ch_ok) begin
            level_val = '0;
            led_val   = '0;
        end else begin
            level_val = (avg_reg > eslt_pkg::LEVEL_CAP_Q16) ? eslt_pkg::LEVEL_FORCED
                      : lvl_prod_reg[eslt_pkg::LEVEL_W+15:16];
            led_val   = (|avg_reg[eslt_pkg::AVG_W-1:24]) ? eslt_pkg::LED_CAP
                      : avg_reg[23:16];
        end
    end

    assign sts.wdiv_last = (wcnt_reg == eslt_pkg::WCNT_W'(eslt_pkg::H_W - 1));
    assign sts.cdiv_last = (cd_cnt_reg == eslt_pkg::CD_CNT_W'(eslt_pkg::CD_DIGITS - 1));

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            ch_reg    <= in_channel;
            b0_reg    <= in_bin_zero;
            sum_reg   <= eslt_pkg::SUM_W'(in_bin_one) + eslt_pkg::SUM_W'(in_bin_two)
                       + eslt_pkg::SUM_W'(in_bin_three);
            cl_reg[0] <= clamp_bin(in_bin_zero);
            cl_reg[1] <= clamp_bin(in_bin_one);
            cl_reg[2] <= clamp_bin(in_bin_two);
            cl_reg[3] <= clamp_bin(in_bin_three);
        end
        if (cmd.mul3) begin
            prod3_reg <= eslt_pkg::PROD3_W'(sum_reg) * eslt_pkg::PROD3_W'(eslt_pkg::RECIP3);
        end
        if (cmd.high) begin
            high_reg <= high_val;
        end
        if (cmd.den_init) begin
            den_reg  <= den_val;
            wrem_reg <= {1'b0, high_reg};
            hq_reg   <= '0;
            wcnt_reg <= '0;
        end
        if (cmd.wdiv_step) begin
            wrem_reg <= wrem_step;
            hq_reg   <= {hq_reg[eslt_pkg::H_W-2:0], wge};
            wcnt_reg <= wcnt_reg + 1'b1;
        end
        if (cmd.mul_hs) begin
            hs_reg <= eslt_pkg::HS_W'(hq_reg) * eslt_pkg::HS_W'(sum_reg);
        end
        if (cmd.cd_load_c) begin
            cd_num_reg <= eslt_pkg::CD_W'(energy_num);
            cd_div_reg <= eslt_pkg::DIV_ENERGY;
            cd_rem_reg <= '0;
            cd_quo_reg <= '0;
            cd_cnt_reg <= '0;
        end
        if (cmd.cd_load_avg) begin
            cd_num_reg <= eslt_pkg::CD_W'(avg_num);
            cd_div_reg <= eslt_pkg::DIV_AVG;
            cd_rem_reg <= '0;
            cd_quo_reg <= '0;
            cd_cnt_reg <= '0;
        end
        if (cmd.cd_step) begin
            cd_num_reg <= {cd_num_reg[eslt_pkg::CD_W-eslt_pkg::CD_DIGIT_W-1:0],
                           {eslt_pkg::CD_DIGIT_W{1'b0}}};
            cd_rem_reg <= cd_rem_step;
            cd_quo_reg <= {cd_quo_reg[eslt_pkg::CD_W-eslt_pkg::CD_DIGIT_W-1:0], cd_qbits};
            cd_cnt_reg <= cd_cnt_reg + 1'b1;
        end
        if (cmd.finish) begin
            avg_reg <= cd_quo_reg[eslt_pkg::AVG_W-1:0];
        end
        if (cmd.level) begin
            lvl_prod_reg <= eslt_pkg::LVL_PROD_W'(avg_reg[eslt_pkg::LVL_SRC_W-1:0])
                          * eslt_pkg::LVL_PROD_W'(eslt_pkg::LEVEL_SCALE);
        end
        if (cmd.out_load) begin
            out_ch_reg    <= ch_reg;
            out_cl_reg    <= cl_reg;
            out_level_reg <= level_val;
            out_led_reg   <= led_val;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < eslt_pkg::CH_DEPTH; i++) begin
                state_reg[i] <= '0;
            end
        end else if (cmd.finish && ch_ok) begin
            state_reg[ch_reg] <= cd_quo_reg[eslt_pkg::AVG_W-1:0];
        end
    end

    assign out_channel    = out_ch_reg;
    assign clamped_zero   = out_cl_reg[0];
    assign clamped_one    = out_cl_reg[1];
    assign clamped_two    = out_cl_reg[2];
    assign clamped_three  = out_cl_reg[3];
    assign activity_level = out_level_reg;
    assign led_brightness = out_led_reg;

    a_wdiv_rem: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.wdiv_step |-> (wrem_reg < den_reg))
        else $error("weight divider remainder out of range");

    a_cdiv_rem: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.cd_step |-> (cd_rem_reg < cd_div_reg))
        else $error("constant divider remainder out of range");

endmodule

// ----- design/emg_spectral_level_tracker.sv -----
// Channel  Dir  Ports                     Payload
// s_       in   s_tvalid/s_tready         s_tuser: channel; s_tdata: four 24-bit bins
// m_       out  m_tvalid/m_tready         m_tuser: out_channel; m_tdata: bins, level, led
//
// One request at a time: the next is taken once the last result is loaded for output.
// Each request passes the serial weight divider, then two radix-16 constant dividers.
// A finished result waits in the output register while the next request is taken.
// Reset (aresetn low, synchronous) clears all channel averages and the handshakes.
// A stalled m_ side holds the block only once the following result is ready.
module emg_spectral_level_tracker (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // [23:0] bin_zero, [47:24] bin_one, [71:48] bin_two, [95:72] bin_three
    input  logic [eslt_pkg::S_TDATA_W-1:0]     s_tdata,
    // [1:0] channel
    input  logic [eslt_pkg::CH_W-1:0]          s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [15:0] clamped_zero, [31:16] clamped_one, [47:32] clamped_two,
    // [63:48] clamped_three, [79:64] activity_level, [87:80] led_brightness
    output logic [eslt_pkg::M_TDATA_W-1:0]     m_tdata,
    // [1:0] out_channel
    output logic [eslt_pkg::CH_W-1:0]          m_tuser
);

    eslt_pkg::cmd_t cmd;
    eslt_pkg::sts_t sts;

    logic [eslt_pkg::CLAMP_W-1:0] clamped_zero;
    logic [eslt_pkg::CLAMP_W-1:0] clamped_one;
    logic [eslt_pkg::CLAMP_W-1:0] clamped_two;
    logic [eslt_pkg::CLAMP_W-1:0] clamped_three;
    logic [eslt_pkg::LEVEL_W-1:0] activity_level;
    logic [eslt_pkg::LED_W-1:0]   led_brightness;

    eslt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    eslt_dp u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .sts            (sts),
        .in_channel     (s_tuser),
        .in_bin_zero    (s_tdata[23:0]),
        .in_bin_one     (s_tdata[47:24]),
        .in_bin_two     (s_tdata[71:48]),
        .in_bin_three   (s_tdata[95:72]),
        .out_channel    (m_tuser),
        .clamped_zero   (clamped_zero),
        .clamped_one    (clamped_one),
        .clamped_two    (clamped_two),
        .clamped_three  (clamped_three),
        .activity_level (activity_level),
        .led_brightness (led_brightness)
    );

    assign m_tdata = {led_brightness, activity_level, clamped_three, clamped_two,
                      clamped_one, clamped_zero};

endmodule

// ----- bench/emg_level_monitor.sv -----
module emg_level_monitor (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    input  logic                               s_tready,
    input  logic [eslt_pkg::S_TDATA_W-1:0]     s_tdata,
    input  logic [eslt_pkg::CH_W-1:0]          s_tuser,
    input  logic                               m_tvalid,
    input  logic                               m_tready,
    input  logic [eslt_pkg::M_TDATA_W-1:0]     m_tdata,
    input  logic [eslt_pkg::CH_W-1:0]          m_tuser,
    output int                                 fail_count,
    output int                                 pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int              AVG_BITS     = eslt_pkg::AVG_W;
    localparam longint unsigned EPS_LSB      = 66;
    localparam longint unsigned LEVEL_CAP    = 64'd42598400;
    localparam logic [15:0]     LEVEL_FORCED = 16'd65000;
    localparam logic [7:0]      LED_MAX      = 8'd255;
    localparam logic [23:0]     BIN_SAT      = 24'd65535;

    typedef struct packed {
        logic [eslt_pkg::CH_W-1:0] chan;
        logic [15:0]               bin0;
        logic [15:0]               bin1;
        logic [15:0]               bin2;
        logic [15:0]               bin3;
        logic [15:0]               level;
        logic [7:0]                led;
    } level_report_t;

    logic [AVG_BITS-1:0] channel_avg [eslt_pkg::CH_DEPTH];
    level_report_t       pending_reports [$];
    string               field_names [0:6] = '{"out_channel", "clamped_zero", "clamped_one",
                                               "clamped_two", "clamped_three",
                                               "activity_level", "led_brightness"};

    initial begin
        fail_count = 0;
        pending    = 0;
    end

    task automatic report_mismatch(input string detail);
        $display("%0t ns mismatch: %s", $realtime, detail);
        fail_count++;
    endtask

    function automatic logic [15:0] sat16(input logic [23:0] bin);
        return (bin > BIN_SAT) ? 16'hFFFF : bin[15:0];
    endfunction

    function automatic level_report_t fold_bins(input logic [eslt_pkg::CH_W-1:0] ch,
                                                input logic [23:0] b0, input logic [23:0] b1,
                                                input logic [23:0] b2, input logic [23:0] b3);
        level_report_t       r;
        longint unsigned     sum;
        longint unsigned     low_q;
        longint unsigned     high_q;
        longint unsigned     weight;
        longint unsigned     energy;
        longint unsigned     avg_wide;
        logic [AVG_BITS-1:0] avg;
        r.chan  = ch;
        r.bin0  = sat16(b0);
        r.bin1  = sat16(b1);
        r.bin2  = sat16(b2);
        r.bin3  = sat16(b3);
        r.level = '0;
        r.led   = '0;
        if (ch < eslt_pkg::CHANNELS) begin
            sum      = 64'(b1) + 64'(b2) + 64'(b3);
            low_q    = 64'(b0) << 15;
            high_q   = (sum << 16) / 6;
            weight   = ((high_q * 2) << 16) / (low_q + high_q + EPS_LSB);
            energy   = weight * sum * 3 / 100;
            avg_wide = (64'(channel_avg[ch]) * 4 + energy) / 5;
            avg      = avg_wide[AVG_BITS-1:0];
            channel_avg[ch] = avg;
            if (64'(avg) > LEVEL_CAP) begin
                r.level = LEVEL_FORCED;
            end else begin
                r.level = 16'((64'(avg) * 100) >> 16);
            end
            r.led = (avg[AVG_BITS-1:16] > LED_MAX) ? LED_MAX : avg[23:16];
        end
        return r;
    endfunction

    // sample at the falling edge: these are the values the next rising edge accepts
    always @(negedge aclk) begin
        level_report_t   want;
        longint unsigned got_f [7];
        longint unsigned want_f [7];
        if (!aresetn) begin
            foreach (channel_avg[k]) channel_avg[k] = '0;
            pending_reports.delete();
        end else begin
            if (s_tvalid && s_tready) begin
                pending_reports.push_back(fold_bins(s_tuser, s_tdata[23:0], s_tdata[47:24],
                                                    s_tdata[71:48], s_tdata[95:72]));
            end
            if (m_tvalid && m_tready) begin
                if (pending_reports.size() == 0) begin
                    report_mismatch($sformatf("result for channel %0d with no request pending",
                                              m_tuser));
                end else begin
                    want   = pending_reports.pop_front();
                    got_f  = '{m_tuser, m_tdata[15:0], m_tdata[31:16], m_tdata[47:32],
                               m_tdata[63:48], m_tdata[79:64], m_tdata[87:80]};
                    want_f = '{want.chan, want.bin0, want.bin1, want.bin2, want.bin3,
                               want.level, want.led};
                    for (int k = 0; k < 7; k++) begin
                        if (got_f[k] != want_f[k]) begin
                            report_mismatch($sformatf("%s got %0d, expected %0d",
                                                      field_names[k], got_f[k], want_f[k]));
                        end
                    end
                end
            end
        end
        pending = pending_reports.size();
    end

endmodule

// ----- bench/tb_top.sv -----
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int              STALL_LIMIT   = 4000;
    localparam int              ITEMS_PER_RUN = 627;
    localparam longint unsigned CAP_HS3       = 64'd21299200000;

    logic                           aclk;
    logic                           aresetn  = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [eslt_pkg::S_TDATA_W-1:0] s_tdata  = '0;
    logic [eslt_pkg::CH_W-1:0]      s_tuser  = '0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [eslt_pkg::M_TDATA_W-1:0] m_tdata;
    logic [eslt_pkg::CH_W-1:0]      m_tuser;
    int                             fail_count;
    int                             pending;
    int                             src_idle_pct  = 35;
    int                             sink_idle_pct = 66;
    int                             stall_cycles  = 0;

    emg_spectral_level_tracker dut (.*);

    emg_level_monitor monitor (.*);

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= sink_idle_pct);
    end

    always @(negedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
        end
        if (stall_cycles == STALL_LIMIT) begin
            $display("no request moved for %0d cycles", STALL_LIMIT);
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic push_bins(input logic [1:0] ch, input logic [23:0] b0, input logic [23:0] b1,
                             input logic [23:0] b2, input logic [23:0] b3);
        logic taken;
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= ch;
        s_tdata  <= {b3, b2, b1, b0};
        do begin
            @(negedge aclk);
            taken = s_tready;
            @(posedge aclk);
        end while (!taken);
    endtask

    function automatic logic [23:0] noise_bin();
        case ($urandom_range(5))
            0: return 24'd0;
            1: return 24'hFFFFFF;
            2: return 24'($urandom_range(65537, 65534));
            3: return 24'($urandom_range(255));
            default: return 24'($urandom() >> $urandom_range(8, 31));
        endcase
    endfunction

    initial begin
        bit              cap_found;
        logic [23:0]     cap_b0;
        longint unsigned cap_sum;
        longint unsigned s;
        longint unsigned hq;
        longint unsigned h;
        longint unsigned hmax;
        longint          est;
        longint          cand;
        logic [1:0]      burst_ch;
        int              burst_shift;
        int              burst_left;

        // find bins that take a fresh channel's average to exactly 650.0
        cap_found = 1'b0;
        cap_b0    = '0;
        cap_sum   = 0;
        for (s = 54000; s < 200000 && !cap_found; s++) begin
            hq   = (s << 16) / 6;
            h    = (CAP_HS3 + 3 * s - 1) / (3 * s);
            hmax = ((hq * 2) << 16) / (hq + 66);
            if (h <= hmax && 3 * h * s <= CAP_HS3 + 499) begin
                est = (longint'(((hq * 2) << 16) / h) - longint'(hq) - 66) / 32768;
                for (cand = est - 1; cand <= est + 2; cand++) begin
                    if (!cap_found && cand >= 0 && cand <= 64'hFFFFFF &&
                        ((hq * 2) << 16) / ($unsigned(cand) * 32768 + hq + 66) == h) begin
                        cap_found = 1'b1;
                        cap_b0    = 24'(cand);
                        cap_sum   = s;
                    end
                end
            end
        end

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        if (cap_found) begin
            push_bins(2'd3, cap_b0, 24'(cap_sum / 3), 24'(cap_sum / 3),
                      24'(cap_sum - 2 * (cap_sum / 3)));
        end
        push_bins(2'd3, 24'd0, 24'd0, 24'd0, 24'd0);
        push_bins(2'd0, 24'd0, 24'd0, 24'd0, 24'd0);
        push_bins(2'd0, 24'hFFFFFF, 24'd0, 24'd0, 24'd0);
        repeat (3) push_bins(2'd1, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
        // drive the average past the level cap and the LED saturation point
        repeat (5) push_bins(2'd2, 24'd0, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
        push_bins(2'd0, 24'd65535, 24'd65536, 24'd65534, 24'd1);
        push_bins(2'd1, 24'd0, 24'd65535, 24'd65536, 24'hAAAAAA);
        push_bins(2'd3, 24'h555555, 24'hAAAAAA, 24'h555555, 24'd0);
        push_bins(2'd0, 24'd0, 24'd1, 24'd0, 24'd0);
        repeat (2) push_bins(2'd2, 24'd0, 24'd0, 24'd0, 24'd0);

        burst_left  = 0;
        burst_ch    = '0;
        burst_shift = 8;
        for (int phase = 0; phase < 3; phase++) begin
            if (phase > 0) begin
                src_idle_pct  = (phase == 1) ? 66 : 0;
                sink_idle_pct = (phase == 1) ? 35 : 0;
                // hold off until the block has drained
                s_tvalid <= 1'b0;
                while (pending != 0) @(posedge aclk);
            end
            for (int i = 0; i < ITEMS_PER_RUN; i++) begin
                if (burst_left == 0) begin
                    burst_ch    = 2'($urandom_range(3));
                    burst_shift = $urandom_range(8, 31);
                    burst_left  = $urandom_range(1, 12);
                end
                burst_left--;
                if ($urandom_range(5) == 0) begin
                    push_bins(2'($urandom_range(3)), noise_bin(), noise_bin(), noise_bin(),
                              noise_bin());
                end else begin
                    push_bins(burst_ch,
                              24'($urandom() >> (burst_shift + $urandom_range(1))),
                              24'($urandom() >> (burst_shift + $urandom_range(1))),
                              24'($urandom() >> (burst_shift + $urandom_range(1))),
                              24'($urandom() >> (burst_shift + $urandom_range(1))));
                end
            end
        end

        s_tvalid <= 1'b0;
        while (pending != 0) @(posedge aclk);
        repeat (64) @(posedge aclk);

        if (pending != 0) begin
            $display("%0d results never arrived", pending);
        end
        if (fail_count == 0 && pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
